// ===== rtl/core/slwc_pkg.sv =====
// ----------------------------------------------------------------------------
// slwc_pkg
// Shared types and constants for the sized literal width checker: verdict
// and phase codes, base codes and the character codes of the literal form.
// ----------------------------------------------------------------------------
package slwc_pkg;

  typedef enum logic [2:0] {
    VERDICT_NO_MATCH      = 3'd0,
    VERDICT_WIDTH_SKIPPED = 3'd1,
    VERDICT_VALUE_INVALID = 3'd2,
    VERDICT_FITS          = 3'd3,
    VERDICT_OVERFLOWS     = 3'd4
  } verdict_t;

  typedef enum logic [1:0] {
    PHASE_WIDTH = 2'd0,
    PHASE_BASE  = 2'd1,
    PHASE_VALUE = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    BASE_BIN = 2'd0,
    BASE_OCT = 2'd1,
    BASE_DEC = 2'd2,
    BASE_HEX = 2'd3
  } base_t;

  localparam logic [6:0] WIDTH_SAT = 7'd64;

  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_APOS   = 8'h27;
  localparam logic [7:0] CH_UNDER  = 8'h5f;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_CASE   = 8'h20;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_B  = 8'h62;
  localparam logic [7:0] CH_LOW_D  = 8'h64;
  localparam logic [7:0] CH_LOW_F  = 8'h66;
  localparam logic [7:0] CH_LOW_H  = 8'h68;
  localparam logic [7:0] CH_LOW_O  = 8'h6f;

  localparam logic [4:0] DIGIT_NONE = 5'd16;

  function automatic logic [4:0] radix_of(input base_t base);
    logic [4:0] r;
    case (base)
      BASE_BIN: r = 5'd2;
      BASE_OCT: r = 5'd8;
      BASE_DEC: r = 5'd10;
      BASE_HEX: r = 5'd16;
      default:  r = 5'd16;
    endcase
    return r;
  endfunction

  // hex digit value of a character, or DIGIT_NONE
  function automatic logic [4:0] digit_of(input logic [7:0] c);
    logic [7:0] folded;
    logic [4:0] d;
    folded = c | CH_CASE;
    if (c inside {[CH_ZERO:CH_NINE]}) begin
      d = 5'(c - CH_ZERO);
    end else if (folded inside {[CH_LOW_A:CH_LOW_F]}) begin
      d = 5'(folded - CH_LOW_A) + 5'd10;
    end else begin
      d = DIGIT_NONE;
    end
    return d;
  endfunction

endpackage

// ===== rtl/core/sized_literal_width_checker_unit.sv =====
// ----------------------------------------------------------------------------
// sized_literal_width_checker_unit
// A final character is held in the input register, and its verdict is registered from there.
// Throughput: one character per cycle; a final character waits in the input
// register while the previous verdict is still held downstream.
// Reset: synchronous; clears the pipeline and returns the parser to the
// width digits phase. The parser also returns there after every verdict.
// ----------------------------------------------------------------------------
module sized_literal_width_checker_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  logic [7:0]          char_code,
  input  logic                last_char,
  output logic                result_valid,
  input  logic                result_stall,
  output slwc_pkg::verdict_t  verdict,
  output logic [63:0]         parsed_value,
  output logic [6:0]          declared_width,
  output logic [62:0]         max_value
);
  import slwc_pkg::*;

  logic        s1_valid;
  logic [7:0]  s1_char;
  logic        s1_last;
  logic        s1_go;

  phase_t      phase, phase_next;
  logic [6:0]  width_acc, width_acc_next;
  logic        width_seen, width_seen_next;
  base_t       base_code, base_code_next;
  logic [63:0] value_acc, value_acc_next;
  logic        value_chars_seen, value_chars_seen_next;
  logic        value_digit_seen, value_digit_seen_next;
  logic        value_bad, value_bad_next;
  logic        form_bad, form_bad_next;

  logic [3:0]  dec_digit;
  logic [9:0]  width_sum;
  logic [4:0]  digit;
  logic [4:0]  radix;
  logic [67:0] value_scaled;
  logic [67:0] value_sum;
  logic [7:0]  folded;
  logic [63:0] max_full;

  verdict_t    verdict_next;
  logic [63:0] parsed_value_next;
  logic [62:0] max_value_next;

  assign item_stall = s1_valid && s1_last && result_valid && result_stall;
  assign s1_go      = s1_valid && !item_stall;

  always_comb begin
    dec_digit    = 4'(s1_char - CH_ZERO);
    width_sum    = ({3'b0, width_acc} << 3) + ({3'b0, width_acc} << 1) + {6'b0, dec_digit};
    digit        = digit_of(s1_char);
    radix        = radix_of(base_code);
    folded       = s1_char | CH_CASE;
    case (base_code)
      BASE_BIN: value_scaled = {4'b0, value_acc} << 1;
      BASE_OCT: value_scaled = {4'b0, value_acc} << 3;
      BASE_DEC: value_scaled = ({4'b0, value_acc} << 3) + ({4'b0, value_acc} << 1);
      BASE_HEX: value_scaled = {4'b0, value_acc} << 4;
      default:  value_scaled = {4'b0, value_acc} << 4;
    endcase
    value_sum = value_scaled + {63'b0, digit};

    phase_next            = phase;
    width_acc_next        = width_acc;
    width_seen_next       = width_seen;
    base_code_next        = base_code;
    value_acc_next        = value_acc;
    value_chars_seen_next = value_chars_seen;
    value_digit_seen_next = value_digit_seen;
    value_bad_next        = value_bad;
    form_bad_next         = form_bad;

    if (!form_bad) begin
      case (phase)
        PHASE_WIDTH: begin
          if (s1_char inside {[CH_ZERO:CH_NINE]}) begin
            width_acc_next  = (width_sum > {3'b0, WIDTH_SAT}) ? WIDTH_SAT : width_sum[6:0];
            width_seen_next = 1'b1;
          end else if (s1_char == CH_APOS && width_seen) begin
            phase_next = PHASE_BASE;
          end else begin
            form_bad_next = 1'b1;
          end
        end
        PHASE_BASE: begin
          phase_next = PHASE_VALUE;
          case (folded)
            CH_LOW_B: base_code_next = BASE_BIN;
            CH_LOW_O: base_code_next = BASE_OCT;
            CH_LOW_D: base_code_next = BASE_DEC;
            CH_LOW_H: base_code_next = BASE_HEX;
            default: begin
              phase_next    = PHASE_BASE;
              form_bad_next = 1'b1;
            end
          endcase
        end
        default: begin
          value_chars_seen_next = 1'b1;
          if (s1_char == CH_LF || s1_char == CH_CR) begin
            form_bad_next = 1'b1;
          end else if (s1_char != CH_UNDER && !value_bad) begin
            if (digit >= radix || (|value_sum[67:64])) begin
              value_bad_next = 1'b1;
            end else begin
              value_acc_next        = value_sum[63:0];
              value_digit_seen_next = 1'b1;
            end
          end
        end
      endcase
    end

    max_full          = (64'd1 << width_acc_next[5:0]) - 64'd1;
    parsed_value_next = '0;
    max_value_next    = '0;
    if (form_bad_next || phase_next != PHASE_VALUE || !value_chars_seen_next) begin
      verdict_next = VERDICT_NO_MATCH;
    end else if (width_acc_next == 7'd0 || width_acc_next >= WIDTH_SAT) begin
      verdict_next = VERDICT_WIDTH_SKIPPED;
    end else if (value_bad_next || !value_digit_seen_next || (&value_acc_next)) begin
      verdict_next = VERDICT_VALUE_INVALID;
    end else begin
      parsed_value_next = value_acc_next;
      max_value_next    = max_full[62:0];
      verdict_next      = (value_acc_next > max_full) ? VERDICT_OVERFLOWS : VERDICT_FITS;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid         <= 1'b0;
      result_valid     <= 1'b0;
      phase            <= PHASE_WIDTH;
      width_acc        <= '0;
      width_seen       <= 1'b0;
      base_code        <= BASE_BIN;
      value_acc        <= '0;
      value_chars_seen <= 1'b0;
      value_digit_seen <= 1'b0;
      value_bad        <= 1'b0;
      form_bad         <= 1'b0;
    end else begin
      if (!item_stall) begin
        s1_valid <= item_valid;
        s1_char  <= char_code;
        s1_last  <= last_char;
      end
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      if (s1_go) begin
        if (s1_last) begin
          result_valid     <= 1'b1;
          verdict          <= verdict_next;
          parsed_value     <= parsed_value_next;
          declared_width   <= width_acc_next;
          max_value        <= max_value_next;
          // back to the start for the next literal
          phase            <= PHASE_WIDTH;
          width_acc        <= '0;
          width_seen       <= 1'b0;
          base_code        <= BASE_BIN;
          value_acc        <= '0;
          value_chars_seen <= 1'b0;
          value_digit_seen <= 1'b0;
          value_bad        <= 1'b0;
          form_bad         <= 1'b0;
        end else begin
          phase            <= phase_next;
          width_acc        <= width_acc_next;
          width_seen       <= width_seen_next;
          base_code        <= base_code_next;
          value_acc        <= value_acc_next;
          value_chars_seen <= value_chars_seen_next;
          value_digit_seen <= value_digit_seen_next;
          value_bad        <= value_bad_next;
          form_bad         <= form_bad_next;
        end
      end
    end
  end

endmodule

// ===== bench/tb_sized_literal_width_checker_unit.sv =====
// ----------------------------------------------------------------------------
// tb_sized_literal_width_checker_unit
// Feeds sized literal text one character per transaction. The verdict of
// each literal is predicted when its final character is accepted, and every
// result transaction is checked field by field against it. A directed set of
// literal forms comes first, then random literals (mostly well formed, some
// broken, some noise) under three idling regimes on both channels.
// ----------------------------------------------------------------------------
module tb_sized_literal_width_checker_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import slwc_pkg::*;

  typedef struct packed {
    verdict_t    verdict;
    logic [63:0] value;
    logic [6:0]  width;
    logic [62:0] ceiling;
  } literal_verdict_t;

  logic               clk;
  logic               rst = 1'b1;
  logic               item_valid = 1'b0;
  logic               item_stall;
  logic [7:0]         char_code = 8'h00;
  logic               last_char = 1'b0;
  logic               result_valid;
  logic               result_stall = 1'b0;
  verdict_t           verdict;
  logic [63:0]        parsed_value;
  logic [6:0]         declared_width;
  logic [62:0]        max_value;

  literal_verdict_t   verdict_q[$];
  int                 mismatches = 0;
  int                 chars_sent = 0;
  int                 send_idle_pct = 0;
  int                 recv_idle_pct = 0;
  string              base_letters = "bBoOdDhH";

  // literal parser state
  phase_t             lit_phase;
  logic [6:0]         lit_width;
  logic               lit_width_seen;
  base_t              lit_base;
  logic [63:0]        lit_value;
  logic               lit_chars_seen;
  logic               lit_digit_seen;
  logic               lit_value_bad;
  logic               lit_form_bad;

  sized_literal_width_checker_unit u_top (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .char_code      (char_code),
    .last_char      (last_char),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .verdict        (verdict),
    .parsed_value   (parsed_value),
    .declared_width (declared_width),
    .max_value      (max_value)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic void clear_literal();
    lit_phase      = PHASE_WIDTH;
    lit_width      = 7'd0;
    lit_width_seen = 1'b0;
    lit_base       = BASE_BIN;
    lit_value      = 64'd0;
    lit_chars_seen = 1'b0;
    lit_digit_seen = 1'b0;
    lit_value_bad  = 1'b0;
    lit_form_bad   = 1'b0;
  endfunction

  function automatic logic [4:0] char_digit(input logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) begin
      return 5'(c - CH_ZERO);
    end
    if ((c | CH_CASE) >= CH_LOW_A && (c | CH_CASE) <= CH_LOW_F && c >= 8'h40) begin
      return 5'((c | CH_CASE) - CH_LOW_A) + 5'd10;
    end
    return DIGIT_NONE;
  endfunction

  function automatic logic [4:0] base_radix(input base_t b);
    case (b)
      BASE_BIN: return 5'd2;
      BASE_OCT: return 5'd8;
      BASE_DEC: return 5'd10;
      default:  return 5'd16;
    endcase
  endfunction

  function automatic void track_literal_char(input logic [7:0] c);
    logic [4:0]  d;
    logic [4:0]  r;
    logic [67:0] grown;
    int          w;
    if (lit_form_bad) return;
    case (lit_phase)
      PHASE_WIDTH: begin
        if (c >= CH_ZERO && c <= CH_NINE) begin
          w = int'(lit_width) * 10 + int'(c - CH_ZERO);
          lit_width = (w > 64) ? WIDTH_SAT : 7'(w);
          lit_width_seen = 1'b1;
        end else if (c == CH_APOS && lit_width_seen) begin
          lit_phase = PHASE_BASE;
        end else begin
          lit_form_bad = 1'b1;
        end
      end
      PHASE_BASE: begin
        case (c | CH_CASE)
          CH_LOW_B: lit_base = BASE_BIN;
          CH_LOW_O: lit_base = BASE_OCT;
          CH_LOW_D: lit_base = BASE_DEC;
          CH_LOW_H: lit_base = BASE_HEX;
          default:  lit_form_bad = 1'b1;
        endcase
        if (!lit_form_bad) lit_phase = PHASE_VALUE;
      end
      default: begin
        lit_chars_seen = 1'b1;
        if (c == CH_LF || c == CH_CR) begin
          lit_form_bad = 1'b1;
        end else if (c != CH_UNDER && !lit_value_bad) begin
          d = char_digit(c);
          r = base_radix(lit_base);
          grown = {4'b0000, lit_value} * r + d;
          if (d >= r || grown[67:64] != 4'd0) begin
            lit_value_bad = 1'b1;
          end else begin
            lit_value = grown[63:0];
            lit_digit_seen = 1'b1;
          end
        end
      end
    endcase
  endfunction

  function automatic void finish_literal();
    literal_verdict_t v;
    logic [63:0]      top;
    v.verdict = VERDICT_NO_MATCH;
    v.value   = 64'd0;
    v.width   = lit_width;
    v.ceiling = 63'd0;
    if (lit_form_bad || lit_phase != PHASE_VALUE || !lit_chars_seen) begin
      v.verdict = VERDICT_NO_MATCH;
    end else if (lit_width == 7'd0 || lit_width >= WIDTH_SAT) begin
      v.verdict = VERDICT_WIDTH_SKIPPED;
    end else if (lit_value_bad || !lit_digit_seen || &lit_value) begin
      v.verdict = VERDICT_VALUE_INVALID;
    end else begin
      top = (64'd1 << lit_width) - 64'd1;
      v.value   = lit_value;
      v.ceiling = top[62:0];
      v.verdict = (lit_value > top) ? VERDICT_OVERFLOWS : VERDICT_FITS;
    end
    verdict_q.push_back(v);
    clear_literal();
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  always @(posedge clk) begin
    result_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    literal_verdict_t due;
    if (!rst && result_valid && !result_stall) begin
      if (verdict_q.size() == 0) begin
        report_mismatch("unexpected result transaction", 64'(verdict), 64'd0);
      end else begin
        due = verdict_q.pop_front();
        if (verdict !== due.verdict)
          report_mismatch("verdict", 64'(verdict), 64'(due.verdict));
        if (parsed_value !== due.value)
          report_mismatch("parsed_value", parsed_value, due.value);
        if (declared_width !== due.width)
          report_mismatch("declared_width", 64'(declared_width), 64'(due.width));
        if (max_value !== due.ceiling)
          report_mismatch("max_value", 64'(max_value), 64'(due.ceiling));
      end
    end
  end

  task automatic send_char(input logic [7:0] c, input logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    char_code  <= c;
    last_char  <= fin;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    chars_sent++;
    track_literal_char(c);
    if (fin) finish_literal();
  endtask

  task automatic send_text(input string s, input bit ends);
    for (int i = 0; i < s.len(); i++) begin
      send_char(s[i], ends && (i == s.len() - 1));
    end
  endtask

  task automatic test_drain_pause();
    item_valid <= 1'b0;
    @(posedge clk);
    while (verdict_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed_forms();
    send_text("8'hFF", 1);
    send_text("4'O17", 1);
    send_text("3'd9", 1);
    send_text("1'b1", 1);
    send_text("63'h7fff_FFFF_ffff_FFFF", 1);
    send_text("0'd5", 1);
    send_text("64'h1", 1);
    send_text("999'b1", 1);
    send_text("'h1", 1);
    send_text("8x'h1", 1);
    send_text("8'q1", 1);
    send_text("8'h", 1);
    send_text("8'", 1);
    send_text("5", 1);
    send_text("8'b_", 1);
    send_text("8'b2", 1);
    send_text("8'hg", 1);
    send_text("8'hFFFF_FFFF_FFFF_FFFF", 1);
    send_text("8'd18446744073709551616", 1);
    send_text("8'd18446744073709551614", 1);
    send_text("8'h1\n", 1);
    send_text("8'h1", 0);
    send_char(CH_CR, 1'b1);
    send_text("12'd4_0_95_", 1);
    send_char(8'hFF, 1'b0);
    send_char(8'h00, 1'b1);
  endtask

  task automatic test_random_literals(input int quota);
    byte unsigned txt[$];
    string        w_text;
    int           start;
    int           w;
    int           b;
    int           n;
    int           fit;
    int           apos;
    int           d;
    bit           all_max;
    logic [4:0]   r;
    start = chars_sent;
    while (chars_sent - start < quota) begin
      txt.delete();
      if ($urandom_range(9) == 0) begin
        n = $urandom_range(1, 6);
        repeat (n) txt.push_back(8'($urandom_range(255)));
      end else begin
        case ($urandom_range(9))
          0:       w = $urandom_range(1) ? 0 : $urandom_range(64, 300);
          1:       w = 64;
          default: w = $urandom_range(1, 63);
        endcase
        w_text = $sformatf("%0d", w);
        if ($urandom_range(7) == 0) w_text = {"0", w_text};
        for (int i = 0; i < w_text.len(); i++) txt.push_back(w_text[i]);
        apos = txt.size();
        txt.push_back(CH_APOS);
        b = $urandom_range(3);
        txt.push_back(base_letters[2 * b + $urandom_range(1)]);
        r = base_radix(base_t'(b));
        fit = (w < 1) ? 1 : ((w > 63) ? 63 : w);
        case (base_t'(b))
          BASE_BIN: fit = fit;
          BASE_HEX: fit = (fit + 3) / 4;
          default:  fit = (fit + 2) / 3;
        endcase
        if ($urandom_range(3) == 0) begin
          n = $urandom_range(1, (r == 5'd2) ? 66 : (r == 5'd8) ? 23 : (r == 5'd10) ? 21 : 17);
        end else begin
          n = $urandom_range(1, fit + 1);
        end
        all_max = ($urandom_range(9) == 0);
        repeat (n) begin
          if ($urandom_range(11) == 0) txt.push_back(CH_UNDER);
          if ($urandom_range(39) == 0) begin
            txt.push_back(8'($urandom_range(CH_ZERO, 8'h7a)));
          end else begin
            d = all_max ? int'(r) - 1 : $urandom_range(int'(r) - 1);
            if (d < 10) txt.push_back(8'(CH_ZERO + d));
            else if ($urandom_range(1)) txt.push_back(8'(CH_LOW_A + d - 10));
            else txt.push_back(8'((CH_LOW_A & ~CH_CASE) + d - 10));
          end
        end
        if ($urandom_range(7) == 0) begin
          case ($urandom_range(4))
            0: txt.delete(apos);
            1: txt[apos + 1] = 8'($urandom_range(255));
            2: while (txt.size() > apos + 2) void'(txt.pop_back());
            3: txt.insert($urandom_range(apos + 2, txt.size()),
                          $urandom_range(1) ? CH_LF : CH_CR);
            default: txt[$urandom_range(txt.size() - 1)] = 8'($urandom_range(255));
          endcase
        end
      end
      foreach (txt[i]) send_char(txt[i], i == txt.size() - 1);
    end
  endtask

  initial begin
    clear_literal();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_forms();
    test_drain_pause();
    send_idle_pct = 29;
    recv_idle_pct = 83;
    test_random_literals(300);
    test_drain_pause();
    send_idle_pct = 83;
    recv_idle_pct = 29;
    test_random_literals(300);
    test_drain_pause();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_literals(300);
    test_drain_pause();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
